// ----- rtl/bps_pkg.sv -----
package bps_pkg;

    // Image and arithmetic sizing.
    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 256;
    localparam int CHANNEL_BITS = 16;
    localparam int FRAC_BITS    = 8;

    // Fixed widths of the beat fields.
    localparam int COORD_BITS   = 18;
    localparam int OUT_CH_BITS  = 16;
    localparam int WR_CH_BITS   = 16;
    localparam int PIXPOS_BITS  = 8;
    localparam int CFG_BITS     = 9;
    localparam int CFG_IDX_BITS = 1;
    localparam int NUM_CH       = 4;

    // Derived sizes.
    localparam int SCALE     = 1 << FRAC_BITS;
    localparam int INT_BITS  = COORD_BITS - 1 - FRAC_BITS;
    localparam int XW        = $clog2(MAX_WIDTH);
    localparam int YW        = $clog2(MAX_HEIGHT);
    localparam int PIX_BITS  = NUM_CH * CHANNEL_BITS;
    localparam int BANK_COLS = (MAX_WIDTH + 1) / 2;
    localparam int BANK_ROWS = (MAX_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = BANK_COLS * BANK_ROWS;
    localparam int BANK_AW   = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int NUM_BANKS = 4;

    // Width of one horizontal blend and of the final weighted sum.
    localparam int LERP_BITS = CHANNEL_BITS + FRAC_BITS + 1;
    localparam int SUM_BITS  = LERP_BITS + FRAC_BITS + 1;

    // Action codes.
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // Bank address of a pixel from its halved column and row.
    function automatic logic [BANK_AW-1:0] bank_addr(input int col_half, input int row_half);
        return BANK_AW'(row_half * BANK_COLS + col_half);
    endfunction

    // Halved index of the neighbor that a bank of the given parity holds.
    function automatic int pick_half(input int idx, input logic par);
        int h;
        if (par) begin
            h = idx >> 1;
        end else begin
            h = (idx + 1) >> 1;
        end
        return h;
    endfunction

    // Image size as written, forced into 1..maxv.
    function automatic int clamp_size(input logic [CFG_BITS-1:0] v, input int maxv);
        int s;
        s = int'(v);
        if (s == 0) begin
            s = 1;
        end else if (s > maxv) begin
            s = maxv;
        end
        return s;
    endfunction

endpackage

// ----- rtl/bps_in_if.sv -----
interface bps_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  action;
    logic signed [bps_pkg::COORD_BITS-1:0] sample_x;
    logic signed [bps_pkg::COORD_BITS-1:0] sample_y;
    logic [bps_pkg::PIXPOS_BITS-1:0]       pixel_col;
    logic [bps_pkg::PIXPOS_BITS-1:0]       pixel_row;
    logic [bps_pkg::WR_CH_BITS-1:0]        write_red;
    logic [bps_pkg::WR_CH_BITS-1:0]        write_green;
    logic [bps_pkg::WR_CH_BITS-1:0]        write_blue;
    logic [bps_pkg::WR_CH_BITS-1:0]        write_alpha;

    modport source (
        output valid, action, sample_x, sample_y, pixel_col, pixel_row,
               write_red, write_green, write_blue, write_alpha,
        input  ready
    );

    modport sink (
        input  valid, action, sample_x, sample_y, pixel_col, pixel_row,
               write_red, write_green, write_blue, write_alpha,
        output ready
    );
endinterface

// ----- rtl/bps_out_if.sv -----
interface bps_out_if;
    logic                            valid;
    logic                            ready;
    logic [bps_pkg::OUT_CH_BITS-1:0] out_red;
    logic [bps_pkg::OUT_CH_BITS-1:0] out_green;
    logic [bps_pkg::OUT_CH_BITS-1:0] out_blue;
    logic [bps_pkg::OUT_CH_BITS-1:0] out_alpha;
    logic                            outside;

    modport source (
        output valid, out_red, out_green, out_blue, out_alpha, outside,
        input  ready
    );

    modport sink (
        input  valid, out_red, out_green, out_blue, out_alpha, outside,
        output ready
    );
endinterface

// ----- rtl/bps_bank_ram.sv -----
module bps_bank_ram #(
    parameter int DEPTH = 2,
    parameter int AW    = 1,
    parameter int DW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while the read enable is low.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bilinear_pixel_sampler.sv -----
// Channel   Dir  Port         Beat contents
// config    in   i_cfg_*      register index, write data (image width, image height)
// pixel     in   i_in         action, sample coordinate, pixel position, RGBA to write
// result    out  o_out        blended RGBA, outside flag (one beat per sample only)
//
// One beat is taken every cycle unless the input is held off; a sample result passes
// the bank read, horizontal blend, then vertical blend into the output register.
// Four banks split by row and column parity give all four neighbors in the same cycle.
// Reset clears the pipeline valid bits and sets both image sizes to their maximum; the
// pixel store is not cleared. A stalled result register holds its beat while the earlier
// stages keep filling their empty slots, then the input is held off.
module bilinear_pixel_sampler (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [bps_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [bps_pkg::CFG_BITS-1:0]     i_cfg_wdata,
    bps_in_if.sink                           i_in,
    bps_out_if.source                        o_out
);

    localparam int CH = bps_pkg::CHANNEL_BITS;
    localparam int F  = bps_pkg::FRAC_BITS;
    localparam int LW = bps_pkg::LERP_BITS;
    localparam int SW = bps_pkg::SUM_BITS;

    typedef struct packed {
        logic         outside;
        logic         last_col;
        logic         last_row;
        logic         xpar;
        logic         ypar;
        logic [F-1:0] fx;
        logic [F-1:0] fy;
    } t_s1;

    typedef struct packed {
        logic         outside;
        logic [F-1:0] fy;
    } t_s2;

    typedef struct packed {
        logic [bps_pkg::OUT_CH_BITS-1:0] red;
        logic [bps_pkg::OUT_CH_BITS-1:0] green;
        logic [bps_pkg::OUT_CH_BITS-1:0] blue;
        logic [bps_pkg::OUT_CH_BITS-1:0] alpha;
        logic                            outside;
    } t_out;

    logic [bps_pkg::XW-1:0] r_wlast;
    logic [bps_pkg::YW-1:0] r_hlast;

    logic    r_v1, r_v2, r_ov;
    t_s1     r_s1, n_s1;
    t_s2     r_s2;
    t_out    r_out, n_out;
    logic [LW-1:0] r_top [bps_pkg::NUM_CH];
    logic [LW-1:0] r_bot [bps_pkg::NUM_CH];
    logic [LW-1:0] n_top [bps_pkg::NUM_CH];
    logic [LW-1:0] n_bot [bps_pkg::NUM_CH];

    logic en1, en2, en3, accept, do_write, in_range;
    logic [bps_pkg::INT_BITS-1:0] xi, yi;
    int xi_int, yi_int;
    logic [1:0] wr_bank;
    logic [bps_pkg::BANK_AW-1:0] wr_addr;
    logic [bps_pkg::PIX_BITS-1:0] wr_data;
    logic [bps_pkg::BANK_AW-1:0] rd_addr [bps_pkg::NUM_BANKS];
    logic [bps_pkg::PIX_BITS-1:0] rd_data [bps_pkg::NUM_BANKS];

    // Configuration registers hold the last column and row index in use.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlast <= bps_pkg::XW'(bps_pkg::clamp_size(9'd256, bps_pkg::MAX_WIDTH) - 1);
            r_hlast <= bps_pkg::YW'(bps_pkg::clamp_size(9'd256, bps_pkg::MAX_HEIGHT) - 1);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                bps_pkg::CFG_IMAGE_WIDTH: begin
                    r_wlast <= bps_pkg::XW'(bps_pkg::clamp_size(i_cfg_wdata,
                                                                bps_pkg::MAX_WIDTH) - 1);
                end
                bps_pkg::CFG_IMAGE_HEIGHT: begin
                    r_hlast <= bps_pkg::YW'(bps_pkg::clamp_size(i_cfg_wdata,
                                                                bps_pkg::MAX_HEIGHT) - 1);
                end
            endcase
        end
    end

    // Stage enables: each stage moves when it is empty or the next one moves.
    assign en3    = !r_ov || o_out.ready;
    assign en2    = !r_v2 || en3;
    assign en1    = !r_v1 || en2;
    assign i_in.ready = en1;
    assign accept = i_in.valid && en1;

    // Sample decode: integer part, fraction and edge tests.
    always_comb begin
        xi     = i_in.sample_x[bps_pkg::COORD_BITS-2:F];
        yi     = i_in.sample_y[bps_pkg::COORD_BITS-2:F];
        xi_int = int'(xi);
        yi_int = int'(yi);
        n_s1.outside  = i_in.sample_x[bps_pkg::COORD_BITS-1]
                     || i_in.sample_y[bps_pkg::COORD_BITS-1]
                     || (xi_int > int'(r_wlast))
                     || (yi_int > int'(r_hlast));
        n_s1.last_col = (xi_int == int'(r_wlast));
        n_s1.last_row = (yi_int == int'(r_hlast));
        n_s1.xpar     = xi[0];
        n_s1.ypar     = yi[0];
        // A dropped direction gets a zero fraction, which makes the full blend exact.
        n_s1.fx = n_s1.last_col ? '0 : i_in.sample_x[F-1:0];
        n_s1.fy = n_s1.last_row ? '0 : i_in.sample_y[F-1:0];
    end

    // Pixel write: bank by parity, address by halved position.
    assign in_range = (int'(i_in.pixel_col) < bps_pkg::MAX_WIDTH)
                   && (int'(i_in.pixel_row) < bps_pkg::MAX_HEIGHT);
    assign do_write = accept && (i_in.action == bps_pkg::ACT_WRITE) && in_range;
    assign wr_bank  = {i_in.pixel_row[0], i_in.pixel_col[0]};
    assign wr_addr  = bps_pkg::bank_addr(int'(i_in.pixel_col) >> 1,
                                         int'(i_in.pixel_row) >> 1);
    assign wr_data  = {CH'(i_in.write_alpha), CH'(i_in.write_blue),
                       CH'(i_in.write_green), CH'(i_in.write_red)};

    // Four parity banks; bank index is {row parity, column parity}.
    for (genvar b = 0; b < bps_pkg::NUM_BANKS; b++) begin : g_bank
        localparam logic CP = 1'((b % 2) == 1);
        localparam logic RP = 1'((b / 2) == 1);

        assign rd_addr[b] = bps_pkg::bank_addr(bps_pkg::pick_half(xi_int, CP),
                                               bps_pkg::pick_half(yi_int, RP));

        bps_bank_ram #(
            .DEPTH (bps_pkg::BANK_DEPTH),
            .AW    (bps_pkg::BANK_AW),
            .DW    (bps_pkg::PIX_BITS)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (do_write && (wr_bank == 2'(b))),
            .i_waddr (wr_addr),
            .i_wdata (wr_data),
            .i_re    (en1),
            .i_raddr (rd_addr[b]),
            .o_rdata (rd_data[b])
        );
    end

    // Stage 1 control travels alongside the bank read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= accept && (i_in.action == bps_pkg::ACT_SAMPLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1 <= n_s1;
        end
    end

    // Stage 1: route banks to neighbors and blend horizontally.
    always_comb begin
        logic [bps_pkg::PIX_BITS-1:0] top_lo, top_hi, bot_lo, bot_hi;
        logic [bps_pkg::PIX_BITS-1:0] p00, p10, p01, p11;
        logic [F:0] wx0, wx1;
        top_lo = r_s1.ypar ? rd_data[2] : rd_data[0];
        top_hi = r_s1.ypar ? rd_data[3] : rd_data[1];
        bot_lo = r_s1.ypar ? rd_data[0] : rd_data[2];
        bot_hi = r_s1.ypar ? rd_data[1] : rd_data[3];
        p00 = r_s1.xpar ? top_hi : top_lo;
        p10 = r_s1.xpar ? top_lo : top_hi;
        p01 = r_s1.xpar ? bot_hi : bot_lo;
        p11 = r_s1.xpar ? bot_lo : bot_hi;
        // Neighbors past the last column or row are not part of the image.
        if (r_s1.last_col) begin
            p10 = '0;
        end
        if (r_s1.last_row) begin
            p01 = '0;
        end
        if (r_s1.last_col || r_s1.last_row) begin
            p11 = '0;
        end
        wx0 = (F+1)'(bps_pkg::SCALE) - {1'b0, r_s1.fx};
        wx1 = {1'b0, r_s1.fx};
        for (int c = 0; c < bps_pkg::NUM_CH; c++) begin
            n_top[c] = LW'(wx0) * LW'(p00[c*CH +: CH]) + LW'(wx1) * LW'(p10[c*CH +: CH]);
            n_bot[c] = LW'(wx0) * LW'(p01[c*CH +: CH]) + LW'(wx1) * LW'(p11[c*CH +: CH]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2.outside <= r_s1.outside;
            r_s2.fy      <= r_s1.fy;
            for (int c = 0; c < bps_pkg::NUM_CH; c++) begin
                r_top[c] <= n_top[c];
                r_bot[c] <= n_bot[c];
            end
        end
    end

    // Stage 2: vertical blend and truncation; off-image samples give zeros.
    always_comb begin
        logic [F:0] wy0, wy1;
        logic [SW-1:0] sum;
        logic [CH-1:0] res [bps_pkg::NUM_CH];
        wy0 = (F+1)'(bps_pkg::SCALE) - {1'b0, r_s2.fy};
        wy1 = {1'b0, r_s2.fy};
        for (int c = 0; c < bps_pkg::NUM_CH; c++) begin
            sum    = SW'(r_top[c]) * SW'(wy0) + SW'(r_bot[c]) * SW'(wy1);
            res[c] = r_s2.outside ? '0 : CH'(sum >> (2 * F));
        end
        n_out.red     = bps_pkg::OUT_CH_BITS'(res[0]);
        n_out.green   = bps_pkg::OUT_CH_BITS'(res[1]);
        n_out.blue    = bps_pkg::OUT_CH_BITS'(res[2]);
        n_out.alpha   = bps_pkg::OUT_CH_BITS'(res[3]);
        n_out.outside = r_s2.outside;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en3) begin
            r_ov <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.out_red   = r_out.red;
    assign o_out.out_green = r_out.green;
    assign o_out.out_blue  = r_out.blue;
    assign o_out.out_alpha = r_out.alpha;
    assign o_out.outside   = r_out.outside;

endmodule

// ----- sim/bilinear_checker.sv -----
module bilinear_checker
    import bps_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]     i_cfg_wdata,
    bps_in_if                       in_ch,
    bps_out_if                      out_ch,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // One blended result as it leaves the block; rgba[0] is red.
    typedef struct packed {
        logic [NUM_CH-1:0][OUT_CH_BITS-1:0] rgba;
        logic                               outside;
    } blend_t;

    // Expected blend together with the coordinate that produced it.
    typedef struct {
        blend_t value;
        int     sx;
        int     sy;
    } blend_expect_t;

    logic [PIX_BITS-1:0] image_copy [MAX_WIDTH*MAX_HEIGHT];
    logic [CFG_BITS-1:0] width_reg;
    logic [CFG_BITS-1:0] height_reg;
    blend_expect_t       pending_blends [$];
    int                  fails;
    int                  checked;

    initial begin
        fails   = 0;
        checked = 0;
    end

    // Register value as the block uses it: zero counts as one, large values saturate.
    function automatic int size_in_use(input logic [CFG_BITS-1:0] v, input int maxv);
        int s;
        s = int'(v);
        if (s == 0) begin
            s = 1;
        end else if (s > maxv) begin
            s = maxv;
        end
        return s;
    endfunction

    function automatic string field_name(input int f);
        case (f)
            0:       return "red";
            1:       return "green";
            2:       return "blue";
            3:       return "alpha";
            default: return "outside";
        endcase
    endfunction

    // Bilinear blend of the stored image at a fixed-point coordinate.
    function automatic blend_t blend_at(input logic [COORD_BITS-1:0] sx_bits,
                                        input logic [COORD_BITS-1:0] sy_bits);
        blend_t              res;
        int                  w;
        int                  h;
        int                  sx;
        int                  sy;
        int                  xi;
        int                  yi;
        bit                  last_col;
        bit                  last_row;
        longint unsigned     fx;
        longint unsigned     fy;
        longint unsigned     a;
        longint unsigned     b;
        longint unsigned     d;
        longint unsigned     e;
        longint unsigned     top;
        longint unsigned     bot;
        longint unsigned     acc;
        logic [PIX_BITS-1:0] p00;
        logic [PIX_BITS-1:0] p10;
        logic [PIX_BITS-1:0] p01;
        logic [PIX_BITS-1:0] p11;

        res = '0;
        w   = size_in_use(width_reg, MAX_WIDTH);
        h   = size_in_use(height_reg, MAX_HEIGHT);
        sx  = int'($signed(sx_bits));
        sy  = int'($signed(sy_bits));

        // Negative coordinates and integer parts past the image are off the image.
        if (sx < 0 || sy < 0) begin
            res.outside = 1'b1;
            return res;
        end
        xi = sx >> FRAC_BITS;
        yi = sy >> FRAC_BITS;
        fx = longint'(sx & (SCALE - 1));
        fy = longint'(sy & (SCALE - 1));
        if (xi > w - 1 || yi > h - 1) begin
            res.outside = 1'b1;
            return res;
        end

        // Neighbors to the right and below exist only away from the last column and row.
        last_col = (xi == w - 1);
        last_row = (yi == h - 1);
        p00 = image_copy[yi*MAX_WIDTH + xi];
        p10 = last_col ? '0 : image_copy[yi*MAX_WIDTH + xi + 1];
        p01 = last_row ? '0 : image_copy[(yi + 1)*MAX_WIDTH + xi];
        p11 = (last_col || last_row) ? '0 : image_copy[(yi + 1)*MAX_WIDTH + xi + 1];

        for (int c = 0; c < NUM_CH; c++) begin
            a = longint'(p00[c*CHANNEL_BITS +: CHANNEL_BITS]);
            b = longint'(p10[c*CHANNEL_BITS +: CHANNEL_BITS]);
            d = longint'(p01[c*CHANNEL_BITS +: CHANNEL_BITS]);
            e = longint'(p11[c*CHANNEL_BITS +: CHANNEL_BITS]);
            if (last_col && last_row) begin
                acc = a;
            end else if (last_col) begin
                acc = ((SCALE - fy) * a + fy * d) >> FRAC_BITS;
            end else if (last_row) begin
                acc = ((SCALE - fx) * a + fx * b) >> FRAC_BITS;
            end else begin
                top = (SCALE - fx) * a + fx * b;
                bot = (SCALE - fx) * d + fx * e;
                acc = (top * (SCALE - fy) + bot * fy) >> (2 * FRAC_BITS);
            end
            res.rgba[c] = acc[OUT_CH_BITS-1:0];
        end
        return res;
    endfunction

    // Track register writes and pixel writes, predict each sample, check each result beat.
    always @(posedge i_clk) begin
        blend_expect_t            want;
        blend_t                   got;
        logic [OUT_CH_BITS-1:0]   ev;
        logic [OUT_CH_BITS-1:0]   av;

        if (!i_rst_n) begin
            width_reg  = CFG_BITS'(MAX_WIDTH);
            height_reg = CFG_BITS'(MAX_HEIGHT);
            pending_blends.delete();
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == CFG_IMAGE_WIDTH) begin
                    width_reg = i_cfg_wdata;
                end else if (i_cfg_index == CFG_IMAGE_HEIGHT) begin
                    height_reg = i_cfg_wdata;
                end
            end

            if (in_ch.valid && in_ch.ready) begin
                if (in_ch.action == ACT_WRITE) begin
                    image_copy[int'(in_ch.pixel_row)*MAX_WIDTH + int'(in_ch.pixel_col)] =
                        {in_ch.write_alpha[CHANNEL_BITS-1:0], in_ch.write_blue[CHANNEL_BITS-1:0],
                         in_ch.write_green[CHANNEL_BITS-1:0], in_ch.write_red[CHANNEL_BITS-1:0]};
                end else begin
                    want.value = blend_at(in_ch.sample_x, in_ch.sample_y);
                    want.sx    = int'($signed(in_ch.sample_x));
                    want.sy    = int'($signed(in_ch.sample_y));
                    pending_blends.push_back(want);
                end
            end

            if (out_ch.valid && out_ch.ready) begin
                got.rgba[0] = out_ch.out_red;
                got.rgba[1] = out_ch.out_green;
                got.rgba[2] = out_ch.out_blue;
                got.rgba[3] = out_ch.out_alpha;
                got.outside = out_ch.outside;
                if (pending_blends.size() == 0) begin
                    $display("%0t: result beat with no sample waiting, expected none, got %h",
                             $time, got);
                    fails++;
                end else begin
                    want = pending_blends.pop_front();
                    checked++;
                    for (int f = 0; f <= NUM_CH; f++) begin
                        if (f < NUM_CH) begin
                            ev = want.value.rgba[f];
                            av = got.rgba[f];
                        end else begin
                            ev = OUT_CH_BITS'(want.value.outside);
                            av = OUT_CH_BITS'(got.outside);
                        end
                        if (ev !== av) begin
                            $display("%0t: %s mismatch at x=%0d y=%0d, expected %h, got %h",
                                     $time, field_name(f), want.sx, want.sy, ev, av);
                            fails++;
                        end
                    end
                end
            end
        end

        o_pending    <= pending_blends.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

// ----- sim/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bps_pkg::*;

    // Everything that one input beat carries; rgba[0] is red.
    typedef struct packed {
        logic                              action;
        logic [COORD_BITS-1:0]             sample_x;
        logic [COORD_BITS-1:0]             sample_y;
        logic [PIXPOS_BITS-1:0]            pixel_col;
        logic [PIXPOS_BITS-1:0]            pixel_row;
        logic [NUM_CH-1:0][WR_CH_BITS-1:0] rgba;
    } pixel_beat_t;

    localparam int NUM_SIZES       = 12;
    localparam int CALM_SIZE       = 9;
    localparam int BEATS_PER_SIZE  = 127;
    localparam int IDLE_PERCENT    = 31;
    localparam int HOLD_OFF_CYCLES = 6;

    // Image sizes as written to the registers, extremes and out-of-range values included.
    logic [CFG_BITS-1:0] width_plan  [NUM_SIZES] =
        '{9'd0, 9'd1, 9'd2, 9'd5, 9'd16, 9'd256, 9'd1, 9'd511, 9'd37, 9'd8, 9'd255, 9'd256};
    logic [CFG_BITS-1:0] height_plan [NUM_SIZES] =
        '{9'd511, 9'd1, 9'd2, 9'd3, 9'd9, 9'd1, 9'd256, 9'd0, 9'd64, 9'd8, 9'd256, 9'd256};

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_wr_en;
    logic [CFG_IDX_BITS-1:0] i_cfg_index;
    logic [CFG_BITS-1:0]     i_cfg_wdata;

    bps_in_if  pix_ch ();
    bps_out_if blend_ch ();

    int fail_count;
    int pending_count;
    int checked_count;

    bit pixel_written [MAX_WIDTH*MAX_HEIGHT];
    int img_w;
    int img_h;
    bit calm;
    int beats_sent;
    int writes_sent;
    int samples_sent;
    int off_image;
    int sizes_run;

    bilinear_pixel_sampler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (pix_ch),
        .o_out       (blend_ch)
    );

    bilinear_checker blend_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .in_ch        (pix_ch),
        .out_ch       (blend_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count)
    );

    always #5 i_clk = ~i_clk;

    // The result side stalls at random except during the calm stretch.
    always @(negedge i_clk) begin
        blend_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    function automatic logic [NUM_CH-1:0][WR_CH_BITS-1:0] random_rgba();
        logic [NUM_CH-1:0][WR_CH_BITS-1:0] v;
        int                                r;
        for (int c = 0; c < NUM_CH; c++) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
                v[c] = '0;
            end else if (r == 1) begin
                v[c] = '1;
            end else begin
                v[c] = WR_CH_BITS'($urandom);
            end
        end
        return v;
    endfunction

    // Fields that a beat does not use still carry random values.
    function automatic pixel_beat_t random_beat();
        pixel_beat_t beat;
        beat.action    = ACT_WRITE;
        beat.sample_x  = COORD_BITS'($urandom);
        beat.sample_y  = COORD_BITS'($urandom);
        beat.pixel_col = PIXPOS_BITS'($urandom);
        beat.pixel_row = PIXPOS_BITS'($urandom);
        beat.rgba      = random_rgba();
        return beat;
    endfunction

    // Integer part biased toward the first and the last pixel.
    function automatic int pick_index(input int n);
        int r;
        r = $urandom_range(0, 99);
        if (n == 1 || r < 20) begin
            return 0;
        end else if (r < 45) begin
            return n - 1;
        end
        return $urandom_range(0, n - 1);
    endfunction

    function automatic int pick_frac();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            return 0;
        end else if (r < 40) begin
            return SCALE - 1;
        end
        return $urandom_range(0, SCALE - 1);
    endfunction

    // Offer one beat, with random gaps before it, and wait until it is taken.
    task automatic drive_beat(input pixel_beat_t beat);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            pix_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.action      <= beat.action;
        pix_ch.sample_x    <= beat.sample_x;
        pix_ch.sample_y    <= beat.sample_y;
        pix_ch.pixel_col   <= beat.pixel_col;
        pix_ch.pixel_row   <= beat.pixel_row;
        pix_ch.write_red   <= beat.rgba[0];
        pix_ch.write_green <= beat.rgba[1];
        pix_ch.write_blue  <= beat.rgba[2];
        pix_ch.write_alpha <= beat.rgba[3];
        @(posedge i_clk);
        while (!pix_ch.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        beats_sent++;
    endtask

    task automatic write_pixel(input int col, input int row,
                               input logic [NUM_CH-1:0][WR_CH_BITS-1:0] rgba);
        pixel_beat_t beat;
        beat           = random_beat();
        beat.action    = ACT_WRITE;
        beat.pixel_col = PIXPOS_BITS'(col);
        beat.pixel_row = PIXPOS_BITS'(row);
        beat.rgba      = rgba;
        drive_beat(beat);
        pixel_written[row*MAX_WIDTH + col] = 1'b1;
        writes_sent++;
    endtask

    // A sample may only read pixels that hold a written value.
    task automatic ensure_pixel(input int col, input int row);
        if (!pixel_written[row*MAX_WIDTH + col]) begin
            write_pixel(col, row, random_rgba());
        end
    endtask

    task automatic sample_at(input int x, input int y);
        pixel_beat_t beat;
        int          xi;
        int          yi;
        xi = x >>> FRAC_BITS;
        yi = y >>> FRAC_BITS;
        if (x >= 0 && y >= 0 && xi < img_w && yi < img_h) begin
            ensure_pixel(xi, yi);
            if (xi != img_w - 1) begin
                ensure_pixel(xi + 1, yi);
            end
            if (yi != img_h - 1) begin
                ensure_pixel(xi, yi + 1);
            end
            if (xi != img_w - 1 && yi != img_h - 1) begin
                ensure_pixel(xi + 1, yi + 1);
            end
        end else begin
            off_image++;
        end
        beat          = random_beat();
        beat.action   = ACT_SAMPLE;
        beat.sample_x = COORD_BITS'(x);
        beat.sample_y = COORD_BITS'(y);
        drive_beat(beat);
        samples_sent++;
    endtask

    // Mostly samples on the image, the rest negative, past the edge or fully random.
    task automatic random_sample();
        int x;
        int y;
        int kind;
        x    = pick_index(img_w) * SCALE + pick_frac();
        y    = pick_index(img_h) * SCALE + pick_frac();
        kind = $urandom_range(0, 99);
        if (kind >= 94) begin
            x = int'($signed(COORD_BITS'($urandom)));
            y = int'($signed(COORD_BITS'($urandom)));
        end else if (kind >= 87) begin
            if ($urandom_range(0, 1) == 1) begin
                x = -int'($urandom_range(1, 1 << (COORD_BITS - 1)));
            end else begin
                y = -int'($urandom_range(1, 1 << (COORD_BITS - 1)));
            end
        end else if (kind >= 80) begin
            if ($urandom_range(0, 1) == 1) begin
                x = $urandom_range(img_w, (1 << INT_BITS) - 1) * SCALE + pick_frac();
            end else begin
                y = $urandom_range(img_h, (1 << INT_BITS) - 1) * SCALE + pick_frac();
            end
        end
        sample_at(x, y);
    endtask

    // Most writes land inside the image in use so that samples see fresh values.
    task automatic random_write();
        int col;
        int row;
        if ($urandom_range(0, 99) < 70) begin
            col = $urandom_range(0, img_w - 1);
            row = $urandom_range(0, img_h - 1);
        end else begin
            col = $urandom_range(0, MAX_WIDTH - 1);
            row = $urandom_range(0, MAX_HEIGHT - 1);
        end
        write_pixel(col, row, random_rgba());
    endtask

    // Registers change only once every result is back and the pipeline has emptied.
    task automatic set_size(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] value);
        int s;
        pix_ch.valid <= 1'b0;
        while (pending_count != 0) begin
            @(negedge i_clk);
        end
        repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        s = int'(value);
        if (idx == CFG_IMAGE_WIDTH) begin
            img_w = (s == 0) ? 1 : ((s > MAX_WIDTH) ? MAX_WIDTH : s);
        end else begin
            img_h = (s == 0) ? 1 : ((s > MAX_HEIGHT) ? MAX_HEIGHT : s);
        end
    endtask

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

    initial begin
        int goal;

        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        i_cfg_wr_en        = 1'b0;
        i_cfg_index        = '0;
        i_cfg_wdata        = '0;
        pix_ch.valid       = 1'b0;
        pix_ch.action      = ACT_WRITE;
        pix_ch.sample_x    = '0;
        pix_ch.sample_y    = '0;
        pix_ch.pixel_col   = '0;
        pix_ch.pixel_row   = '0;
        pix_ch.write_red   = '0;
        pix_ch.write_green = '0;
        pix_ch.write_blue  = '0;
        pix_ch.write_alpha = '0;
        blend_ch.ready     = 1'b0;
        img_w              = MAX_WIDTH;
        img_h              = MAX_HEIGHT;
        calm               = 1'b0;
        beats_sent         = 0;
        writes_sent        = 0;
        samples_sent       = 0;
        off_image          = 0;
        sizes_run          = 1;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: a full-scale and a zero corner, mid and extreme fractions.
        write_pixel(0, 0, '1);
        write_pixel(1, 0, '0);
        write_pixel(0, 1, {16'h0001, 16'h8000, 16'hFFFF, 16'h0000});
        write_pixel(1, 1, '1);
        sample_at(0, 0);
        sample_at(SCALE / 2, SCALE / 2);
        sample_at(SCALE - 1, SCALE - 1);
        sample_at(SCALE - 1, 0);

        // Directed: last column, last row and the last corner of the full image.
        sample_at((MAX_WIDTH - 1) * SCALE + 64, (MAX_HEIGHT - 2) * SCALE + 128);
        sample_at((MAX_WIDTH - 2) * SCALE + 192, (MAX_HEIGHT - 1) * SCALE + 51);
        sample_at((MAX_WIDTH - 1) * SCALE + SCALE - 1, (MAX_HEIGHT - 1) * SCALE + SCALE - 1);

        // Directed: negative, just past the edge and the extreme coordinates.
        sample_at(-1, 0);
        sample_at(0, -(1 << (COORD_BITS - 1)));
        sample_at(MAX_WIDTH * SCALE, 0);
        sample_at(0, MAX_HEIGHT * SCALE);
        sample_at((1 << (COORD_BITS - 1)) - 1, (1 << (COORD_BITS - 1)) - 1);

        // Random traffic under a series of image sizes.
        for (int p = 0; p < NUM_SIZES; p++) begin
            set_size(CFG_IMAGE_WIDTH, width_plan[p]);
            set_size(CFG_IMAGE_HEIGHT, height_plan[p]);
            sizes_run++;
            calm = (p == CALM_SIZE);
            goal = beats_sent + BEATS_PER_SIZE;
            while (beats_sent < goal) begin
                if ($urandom_range(0, 99) < 20) begin
                    random_write();
                end else begin
                    random_sample();
                end
            end
        end
        calm = 1'b0;

        // Drain the outstanding results, then give late beats a chance to show up.
        pix_ch.valid <= 1'b0;
        while (pending_count != 0) begin
            @(negedge i_clk);
        end
        repeat (10) @(negedge i_clk);

        $display("Sent %0d pixel writes and %0d samples (%0d off the image) over %0d image sizes.",
                 writes_sent, samples_sent, off_image, sizes_run);
        $display("Compared %0d blended results, %0d mismatches.", checked_count, fail_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
